/* src/assert_macros.svh */
// Assertion macros shared by the heading core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define CHECK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define CHECK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/mhdg_pkg.sv */
// Shared constants, types and tables for the magnetometer heading core.
package mhdg_pkg;

  // Field widths fixed by the interface.
  localparam int RAW_W   = 13;
  localparam int OFF_W   = 16;
  localparam int DECL_W  = 15;
  localparam int HEAD_W  = 15;
  localparam int GAIN_W  = 11;
  localparam int GSEL_W  = 3;

  // Datapath width of the corrected axes and the CORDIC vector.
  localparam int XW = 29;
  // Width of the heading sum before wrapping, in 1/64 degree.
  localparam int HW = 18;

  localparam int FULL_TURN = 23040;

  // Defaults of the top-level parameters.
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 6;

  // Arctangent table: atan(2^-i) in degrees, scaled by 2^20.
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_FRAC = 20;
  localparam longint ATAN_DEG20 [ATAN_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN_SELECT = 2'd0,
    REG_Y_OFFSET    = 2'd1,
    REG_Z_OFFSET    = 2'd2,
    REG_DECLINATION = 2'd3
  } mhdg_reg_t;

  // Flags that travel with each item through the pipeline.
  typedef struct packed {
    logic ovf;
    logic zero;
  } mhdg_flags_t;

  // Gain in LSB per gauss for each gain index.
  function automatic logic [GAIN_W-1:0] gain_lsb(input logic [GSEL_W-1:0] sel);
    logic [GAIN_W-1:0] g;
    case (sel)
      3'd0:    g = 11'd1370;
      3'd1:    g = 11'd1090;
      3'd2:    g = 11'd820;
      3'd3:    g = 11'd660;
      3'd4:    g = 11'd440;
      3'd5:    g = 11'd390;
      3'd6:    g = 11'd330;
      3'd7:    g = 11'd230;
      default: g = 11'd1090;
    endcase
    return g;
  endfunction

  // Arctangent of step idx in units of 2^-frac degree, rounded half up.
  function automatic longint atan_step(input int idx, input int frac);
    int s;
    s = ATAN_FRAC - frac;
    return (ATAN_DEG20[idx] + (longint'(1) << (s - 1))) >>> s;
  endfunction

endpackage

/* src/mhdg_front.sv */
// Input register, hard-iron correction and half-turn pre-rotation stages.
module mhdg_front import mhdg_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int AW = ANGLE_FRAC_BITS + 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [RAW_W-1:0]  raw_x,
  input  logic signed [RAW_W-1:0]  raw_y,
  input  logic signed [RAW_W-1:0]  raw_z,
  input  logic [GSEL_W-1:0]        gain_select,
  input  logic signed [OFF_W-1:0]  y_offset,
  input  logic signed [OFF_W-1:0]  z_offset,
  output logic                     out_valid,
  output mhdg_flags_t              out_flags,
  output logic signed [XW-1:0]     out_a,
  output logic signed [XW-1:0]     out_b,
  output logic signed [AW-1:0]     out_ang
);

  localparam logic signed [RAW_W-1:0] OVF_CODE = {1'b1, {(RAW_W-1){1'b0}}};
  localparam logic signed [AW-1:0] HALF_TURN = AW'(180 << ANGLE_FRAC_BITS);

  logic                    s0_valid;
  logic signed [RAW_W-1:0] s0_x, s0_y, s0_z;
  logic                    s0_ovf;
  logic signed [XW-1:0]    gain_s;
  logic signed [XW-1:0]    vy_next, vz_next;
  logic                    s1_valid;
  logic                    s1_ovf;
  logic signed [XW-1:0]    s1_y, s1_z;
  logic                    s1_zero;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x <= raw_x;
      s0_y <= raw_y;
      s0_z <= raw_z;
    end
  end

  // Overflow test and correction: raw * 4096 - offset * gain.
  always_comb begin
    s0_ovf  = (s0_x == OVF_CODE) || (s0_y == OVF_CODE) || (s0_z == OVF_CODE);
    gain_s  = XW'($signed({1'b0, gain_lsb(gain_select)}));
    vy_next = (XW'(s0_y) <<< 12) - (XW'(y_offset) * gain_s);
    vz_next = (XW'(s0_z) <<< 12) - (XW'(z_offset) * gain_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ovf <= s0_ovf;
      s1_y   <= vy_next;
      s1_z   <= vz_next;
    end
  end

  // Pre-rotation: a vector in the left half-plane is turned by 180 degrees.
  assign s1_zero = (s1_y == '0) && (s1_z == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags.ovf  <= s1_ovf;
      out_flags.zero <= s1_zero;
      if (s1_y < 0) begin
        out_a   <= -s1_y;
        out_b   <= -s1_z;
        out_ang <= HALF_TURN;
      end else begin
        out_a   <= s1_y;
        out_b   <= s1_z;
        out_ang <= '0;
      end
    end
  end

endmodule

/* src/mhdg_cordic_stage.sv */
// One registered vectoring CORDIC iteration.
module mhdg_cordic_stage import mhdg_pkg::*; #(
  parameter int STEP = 0,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int AW = ANGLE_FRAC_BITS + 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  mhdg_flags_t          in_flags,
  input  logic signed [XW-1:0] in_a,
  input  logic signed [XW-1:0] in_b,
  input  logic signed [AW-1:0] in_ang,
  output logic                 out_valid,
  output mhdg_flags_t          out_flags,
  output logic signed [XW-1:0] out_a,
  output logic signed [XW-1:0] out_b,
  output logic signed [AW-1:0] out_ang
);

  localparam logic signed [AW-1:0] ANG_STEP = AW'(atan_step(STEP, ANGLE_FRAC_BITS));

  logic signed [XW-1:0] da, db;
  logic                 b_pos;

  // Floor shifts of the cross terms and the rotation direction.
  always_comb begin
    da    = in_b >>> STEP;
    db    = in_a >>> STEP;
    b_pos = !in_b[XW-1] && (in_b != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Rotate towards the positive a axis and track the angle.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags <= in_flags;
      if (b_pos) begin
        out_a   <= in_a + da;
        out_b   <= in_b - db;
        out_ang <= in_ang + ANG_STEP;
      end else begin
        out_a   <= in_a - da;
        out_b   <= in_b + db;
        out_ang <= in_ang - ANG_STEP;
      end
    end
  end

endmodule

/* src/mhdg_finish.sv */
// Rounding to 1/64 degree, declination add and wrap into one turn.
module mhdg_finish import mhdg_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int AW = ANGLE_FRAC_BITS + 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  mhdg_flags_t              in_flags,
  input  logic signed [AW-1:0]     in_ang,
  input  logic signed [DECL_W-1:0] declination,
  output logic                     out_valid,
  output logic                     out_ovf,
  output logic [HEAD_W-1:0]        heading
);

  localparam int D = ANGLE_FRAC_BITS - 6;
  localparam logic signed [HW-1:0] FULL_S = HW'(FULL_TURN);

  logic signed [HW-1:0] ang64;
  logic signed [HW-1:0] sum_next;
  logic signed [HW-1:0] h;
  logic signed [HW-1:0] h_lo, h_wrap;

  // Convert the angle to 1/64 degree, rounding half up.
  generate
    if (D > 0) begin : g_round
      localparam logic signed [AW-1:0] HALF_LSB = AW'(1 << (D - 1));
      assign ang64 = HW'((in_ang + HALF_LSB) >>> D);
    end else if (D < 0) begin : g_widen
      assign ang64 = HW'(in_ang) <<< (-D);
    end else begin : g_same
      assign ang64 = HW'(in_ang);
    end
  endgenerate

  // A zero vector counts as an angle of zero.
  assign sum_next = (in_flags.zero ? '0 : ang64) + HW'(declination);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h       <= sum_next;
      out_ovf <= in_flags.ovf;
    end
  end

  // Wrap into 0 .. FULL_TURN-1; the sum lies within two turns either way.
  always_comb begin
    h_lo = h + FULL_S;
    if (h < 0) begin
      h_wrap = (h_lo < 0) ? (h_lo + FULL_S) : h_lo;
    end else if (h >= FULL_S) begin
      h_wrap = h - FULL_S;
    end else begin
      h_wrap = h;
    end
  end

  assign heading = out_ovf ? '0 : h_wrap[HEAD_W-1:0];

endmodule

/* src/magnetometer_heading_core.sv */
// Top level of the magnetometer compass heading core.
//
//  Channel   Direction  Signals                         Content
//  s_axis    in         tvalid tready tdata[39:0]       raw_x, raw_y, raw_z
//  m_axis    out        tvalid tready tdata[15:0] tuser heading; overflow
//  cfg       in         valid ready index[1:0] data     register writes
//
// One item is accepted per cycle while s_axis_tready is high; a result passes
// the front stages, one pipeline stage per CORDIC iteration and the finish stage.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// A result that arrives while m_axis is held goes into a skid register, so the input
// keeps accepting; s_axis_tready falls only when both output places are full.
// Configuration writes are taken every cycle.
`include "assert_macros.svh"

module magnetometer_heading_core import mhdg_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_x [12:0], raw_y [25:13], raw_z [38:26], zero [39]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // heading [14:0], zero [15]
  output logic [15:0] m_axis_tdata,
  // overflow [0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = ANGLE_FRAC_BITS + 11;
  localparam int N  = CORDIC_STEPS;

  logic [GSEL_W-1:0]        gain_select;
  logic signed [OFF_W-1:0]  y_offset;
  logic signed [OFF_W-1:0]  z_offset;
  logic signed [DECL_W-1:0] declination;

  logic adv;
  logic skid_valid;

  logic                 cv    [0:N];
  mhdg_flags_t          cf    [0:N];
  logic signed [XW-1:0] ca    [0:N];
  logic signed [XW-1:0] cb    [0:N];
  logic signed [AW-1:0] cang  [0:N];

  logic              fin_valid;
  logic              fin_ovf;
  logic [HEAD_W-1:0] fin_heading;

  logic [HEAD_W-1:0] m_heading, skid_heading;
  logic              skid_ovf;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_select <= GSEL_W'(1);
      y_offset    <= '0;
      z_offset    <= '0;
      declination <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mhdg_reg_t'(cfg_index))
        REG_GAIN_SELECT: gain_select <= cfg_data[GSEL_W-1:0];
        REG_Y_OFFSET:    y_offset    <= cfg_data;
        REG_Z_OFFSET:    z_offset    <= cfg_data;
        REG_DECLINATION: declination <= cfg_data[DECL_W-1:0];
        default:         ;
      endcase
    end
  end

  // The whole pipeline advances while the skid register is empty.
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  mhdg_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (s_axis_tvalid),
    .raw_x      (s_axis_tdata[12:0]),
    .raw_y      (s_axis_tdata[25:13]),
    .raw_z      (s_axis_tdata[38:26]),
    .gain_select(gain_select),
    .y_offset   (y_offset),
    .z_offset   (z_offset),
    .out_valid  (cv[0]),
    .out_flags  (cf[0]),
    .out_a      (ca[0]),
    .out_b      (cb[0]),
    .out_ang    (cang[0])
  );

  // One pipeline stage per CORDIC iteration.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    mhdg_cordic_stage #(
      .STEP           (i),
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (cv[i]),
      .in_flags (cf[i]),
      .in_a     (ca[i]),
      .in_b     (cb[i]),
      .in_ang   (cang[i]),
      .out_valid(cv[i+1]),
      .out_flags(cf[i+1]),
      .out_a    (ca[i+1]),
      .out_b    (cb[i+1]),
      .out_ang  (cang[i+1])
    );
  end

  mhdg_finish #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (cv[N]),
    .in_flags   (cf[N]),
    .in_ang     (cang[N]),
    .declination(declination),
    .out_valid  (fin_valid),
    .out_ovf    (fin_ovf),
    .heading    (fin_heading)
  );

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= fin_valid;
      end
    end else if (fin_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_heading    <= skid_heading;
        m_axis_tuser <= skid_ovf;
      end else begin
        m_heading    <= fin_heading;
        m_axis_tuser <= fin_ovf;
      end
    end else if (fin_valid && !skid_valid) begin
      skid_heading <= fin_heading;
      skid_ovf     <= fin_ovf;
    end
  end

  assign m_axis_tdata = {1'b0, m_heading};

  // The skid register only fills behind a waiting result.
  `CHECK_IMPLIES(a_skid_behind_out, skid_valid, m_axis_tvalid, "skid full with output empty")
  // An overflow result always carries a zero heading.
  `CHECK_IMPLIES(a_ovf_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "heading not zero")
  // Every heading lies within one turn.
  `CHECK_IMPLIES(a_head_range, m_axis_tvalid, m_heading < HEAD_W'(FULL_TURN), "heading too large")
  // The input stalls exactly when the skid register is occupied.
  `CHECK_ALWAYS(a_ready_skid, s_axis_tready == !skid_valid, "ready does not follow skid state")

endmodule
